FILE: design/supply_current_setpoint_ramp_unit_macros.svh
// assertion macros used by the checker file
`ifndef SUPPLY_CURRENT_SETPOINT_RAMP_UNIT_MACROS_SVH
`define SUPPLY_CURRENT_SETPOINT_RAMP_UNIT_MACROS_SVH

// same-cycle implication, disabled during reset
`define SCSR_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define SCSR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/scsr_pkg.sv
`timescale 1ns / 1ps

package scsr_pkg;

  localparam int NODE_COUNT_DEF   = 27;
  localparam int CURRENT_BITS_DEF = 20;
  localparam int CFG_W            = 16;
  localparam int CFG_IDX_W        = 2;
  localparam int ACT_W            = 5;
  localparam int STEP_W           = 3;

  localparam logic [CFG_IDX_W-1:0] REG_RAMP_PERIOD    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RAMP_STEP      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ZERO_THRESHOLD = 2'd2;

  localparam logic [CFG_W-1:0] RAMP_PERIOD_RST    = 16'd90;
  localparam logic [CFG_W-1:0] RAMP_STEP_RST      = 16'd32;
  localparam logic [CFG_W-1:0] ZERO_THRESHOLD_RST = 16'd8;

  localparam logic [2:0] MODE_STACK_CHECK = 3'd2;
  localparam logic [2:0] MODE_STACK_POWER = 3'd3;

  localparam logic [STEP_W-1:0] STEP_FETCH    = 3'd0;
  localparam logic [STEP_W-1:0] STEP_COUNT    = 3'd1;
  localparam logic [STEP_W-1:0] STEP_DIV_INIT = 3'd2;
  localparam logic [STEP_W-1:0] STEP_DIV      = 3'd3;
  localparam logic [STEP_W-1:0] STEP_RAMP     = 3'd4;
  localparam logic [STEP_W-1:0] STEP_CLAMP    = 3'd5;
  localparam logic [STEP_W-1:0] STEP_WAIT     = 3'd6;
  localparam logic [STEP_W-1:0] STEP_EMIT     = 3'd7;

  typedef enum logic [2:0] {
    OP_FETCH    = 3'd0,
    OP_COUNT    = 3'd1,
    OP_DIV_INIT = 3'd2,
    OP_DIV      = 3'd3,
    OP_RAMP     = 3'd4,
    OP_CLAMP    = 3'd5,
    OP_WAIT     = 3'd6,
    OP_EMIT     = 3'd7
  } op_t;

  typedef enum logic [2:0] {
    C_NEXT       = 3'd0,
    C_ALWAYS     = 3'd1,
    C_NO_INPUT   = 3'd2,
    C_COUNT_MORE = 3'd3,
    C_DIV_MORE   = 3'd4,
    C_OUT_BUSY   = 3'd5
  } cond_t;

  typedef struct packed {
    op_t               op;
    cond_t             cond;
    logic [STEP_W-1:0] target;
  } ctrl_word_t;

  typedef struct packed {
    logic in_valid;
    logic count_more;
    logic div_more;
    logic out_busy;
  } seq_flags_t;

  // microcode program
  function automatic ctrl_word_t ucode(input logic [STEP_W-1:0] step);
    ctrl_word_t w;
    unique case (step)
      STEP_FETCH:    w = '{OP_FETCH,    C_NO_INPUT,   STEP_FETCH};
      STEP_COUNT:    w = '{OP_COUNT,    C_COUNT_MORE, STEP_COUNT};
      STEP_DIV_INIT: w = '{OP_DIV_INIT, C_NEXT,       STEP_FETCH};
      STEP_DIV:      w = '{OP_DIV,      C_DIV_MORE,   STEP_DIV};
      STEP_RAMP:     w = '{OP_RAMP,     C_NEXT,       STEP_FETCH};
      STEP_CLAMP:    w = '{OP_CLAMP,    C_NEXT,       STEP_FETCH};
      STEP_WAIT:     w = '{OP_WAIT,     C_OUT_BUSY,   STEP_WAIT};
      STEP_EMIT:     w = '{OP_EMIT,     C_ALWAYS,     STEP_FETCH};
      default:       w = '{OP_FETCH,    C_NO_INPUT,   STEP_FETCH};
    endcase
    return w;
  endfunction

endpackage

FILE: design/scsr_seq.sv
`timescale 1ns / 1ps

module scsr_seq (
  input  logic                    clk,
  input  logic                    rst_n,
  input  scsr_pkg::seq_flags_t    flags,
  output scsr_pkg::ctrl_word_t    ctrl
);

  logic [scsr_pkg::STEP_W-1:0] step_r;
  logic [scsr_pkg::STEP_W-1:0] step_nxt;
  logic                        take;

  assign ctrl = scsr_pkg::ucode(step_r);

  always_comb begin
    unique case (ctrl.cond)
      scsr_pkg::C_NEXT:       take = 1'b0;
      scsr_pkg::C_ALWAYS:     take = 1'b1;
      scsr_pkg::C_NO_INPUT:   take = !flags.in_valid;
      scsr_pkg::C_COUNT_MORE: take = flags.count_more;
      scsr_pkg::C_DIV_MORE:   take = flags.div_more;
      scsr_pkg::C_OUT_BUSY:   take = flags.out_busy;
      default:                take = 1'b0;
    endcase
    step_nxt = take ? ctrl.target : step_r + scsr_pkg::STEP_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= scsr_pkg::STEP_FETCH;
    end else begin
      step_r <= step_nxt;
    end
  end

endmodule

FILE: design/supply_current_setpoint_ramp_unit.sv
`timescale 1ns / 1ps
// steps: fetch, node count, divider init, radix-2 divide, ramp, clamp, wait, emit; a new
// request is taken only after the previous result is emitted, and out_ready held low stalls
// the wait step; the node count takes one mask bit per cycle, the divider one quotient bit
// reset: synchronous active-low rst_n clears the ramp state and flags, loads the register
// defaults (period 90, step 32, threshold 8); the config port is ready whenever out of reset
module supply_current_setpoint_ramp_unit #(
  parameter int NODE_COUNT   = scsr_pkg::NODE_COUNT_DEF,
  parameter int CURRENT_BITS = scsr_pkg::CURRENT_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [NODE_COUNT-1:0]          in_node_mask,
  input  logic [2:0]                     in_system_mode,
  input  logic                           in_start_hydrogen,
  input  logic [CURRENT_BITS-1:0]        in_total_setpoint,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [CURRENT_BITS-1:0]        out_node_current_set,
  output logic [CURRENT_BITS-1:0]        out_total_current_set,
  output logic [CURRENT_BITS-1:0]        out_node_target,
  output logic [scsr_pkg::ACT_W-1:0]     out_active_nodes,
  output logic                           out_ramp_down_done,
  output logic                           out_ramp_down_active,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [scsr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [scsr_pkg::CFG_W-1:0]     cfg_data
);

  localparam int CB     = CURRENT_BITS;
  localparam int CW     = scsr_pkg::CFG_W;
  localparam int CNT_W  = $clog2(NODE_COUNT + 1);
  localparam int LC_MAX = (NODE_COUNT > CURRENT_BITS) ? NODE_COUNT : CURRENT_BITS;
  localparam int LC_W   = $clog2(LC_MAX);
  localparam int WIDE_W = ((CURRENT_BITS > CW) ? CURRENT_BITS : CW) + 1;

  scsr_pkg::ctrl_word_t ctrl;
  scsr_pkg::seq_flags_t flags;

  // config registers
  logic [CW-1:0] period_r;
  logic [CW-1:0] ramp_step_r;
  logic [CW-1:0] thr_r;

  // captured request
  logic [NODE_COUNT-1:0] mask_r;
  logic [2:0]            mode_r;
  logic                  start_r;
  logic [CB-1:0]         total_r;

  // work registers
  logic [LC_W-1:0]  lcnt_r;
  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] rem_r;
  logic [CB-1:0]    quo_r;

  // ramp state
  logic [CW-1:0] up_cnt_r,   up_cnt_nxt;
  logic [CW-1:0] dn_cnt_r,   dn_cnt_nxt;
  logic [CB-1:0] sp_r,       sp_nxt;
  logic [CB-1:0] tot_r,      tot_nxt;
  logic [CB-1:0] tgt_r,      tgt_nxt;
  logic          done_r,     done_nxt;
  logic          down_r,     down_nxt;

  // output register
  logic                       out_valid_r;
  logic [CB-1:0]              out_sp_r;
  logic [CB-1:0]              out_tot_r;
  logic [CB-1:0]              out_tgt_r;
  logic [scsr_pkg::ACT_W-1:0] out_act_r;
  logic                       out_done_r;
  logic                       out_down_r;

  logic                     in_acc;
  logic [CNT_W:0]           rem2;
  logic                     div_ge;
  logic [CNT_W:0]           rem_diff;
  logic [WIDE_W-1:0]        sp_w, step_w, thr_w, sum_w, diff_w, max_w;
  logic [CW-1:0]            up_inc, dn_inc;
  logic                     power_tick;
  logic [CNT_W+scsr_pkg::ACT_W-1:0] act_ext;

  scsr_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .flags (flags),
    .ctrl  (ctrl)
  );

  assign in_ready  = rst_n && (ctrl.op == scsr_pkg::OP_FETCH);
  assign in_acc    = in_valid && in_ready;
  assign cfg_ready = rst_n;

  assign flags.in_valid   = in_valid;
  assign flags.count_more = (lcnt_r != LC_W'(NODE_COUNT - 1));
  assign flags.div_more   = (lcnt_r != LC_W'(CURRENT_BITS - 1));
  assign flags.out_busy   = out_valid_r && !out_ready;

  // restoring divide step
  assign rem2     = {rem_r, quo_r[CB-1]};
  assign div_ge   = (rem2 >= {1'b0, cnt_r});
  assign rem_diff = rem2 - {1'b0, cnt_r};

  assign sp_w   = {{(WIDE_W-CB){1'b0}}, sp_r};
  assign step_w = {{(WIDE_W-CW){1'b0}}, ramp_step_r};
  assign thr_w  = {{(WIDE_W-CW){1'b0}}, thr_r};
  assign max_w  = {{(WIDE_W-CB){1'b0}}, {CB{1'b1}}};
  assign sum_w  = sp_w + step_w;
  assign diff_w = sp_w - step_w;
  assign up_inc = up_cnt_r + CW'(1);
  assign dn_inc = dn_cnt_r + CW'(1);

  assign power_tick = (cnt_r != '0) && (mode_r == scsr_pkg::MODE_STACK_POWER);
  assign act_ext    = {{scsr_pkg::ACT_W{1'b0}}, cnt_r};

  always_comb begin
    up_cnt_nxt = up_cnt_r;
    dn_cnt_nxt = dn_cnt_r;
    sp_nxt     = sp_r;
    tot_nxt    = tot_r;
    tgt_nxt    = tgt_r;
    done_nxt   = done_r;
    down_nxt   = down_r;
    unique case (ctrl.op)
      scsr_pkg::OP_RAMP: begin
        priority if (cnt_r == '0) begin
          sp_nxt = '0;
        end else if (mode_r <= scsr_pkg::MODE_STACK_CHECK) begin
          tot_nxt = '0;
        end else if (mode_r == scsr_pkg::MODE_STACK_POWER) begin
          tot_nxt = total_r;
          tgt_nxt = quo_r;
          if (start_r) begin
            dn_cnt_nxt = '0;
            done_nxt   = 1'b0;
            down_nxt   = 1'b0;
            up_cnt_nxt = up_inc;
            if (up_inc >= period_r) begin
              sp_nxt     = (sum_w > max_w) ? {CB{1'b1}} : sum_w[CB-1:0];
              up_cnt_nxt = '0;
            end
          end else begin
            up_cnt_nxt = '0;
            down_nxt   = 1'b1;
            dn_cnt_nxt = dn_inc;
            if (dn_inc >= period_r) begin
              sp_nxt     = (sp_w > step_w) ? diff_w[CB-1:0] : '0;
              dn_cnt_nxt = '0;
            end
          end
        end else begin
          sp_nxt = sp_r;
        end
      end
      scsr_pkg::OP_CLAMP: begin
        if (power_tick) begin
          if (start_r) begin
            if (sp_r >= tgt_r) begin
              sp_nxt = tgt_r;
            end
          end else if (sp_w <= thr_w) begin
            sp_nxt   = '0;
            tgt_nxt  = '0;
            done_nxt = 1'b1;
          end
        end
      end
      default: begin
        sp_nxt = sp_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r    <= scsr_pkg::RAMP_PERIOD_RST;
      ramp_step_r <= scsr_pkg::RAMP_STEP_RST;
      thr_r       <= scsr_pkg::ZERO_THRESHOLD_RST;
    end else if (cfg_valid) begin
      if (cfg_index == scsr_pkg::REG_RAMP_PERIOD) begin
        period_r <= cfg_data;
      end
      if (cfg_index == scsr_pkg::REG_RAMP_STEP) begin
        ramp_step_r <= cfg_data;
      end
      if (cfg_index == scsr_pkg::REG_ZERO_THRESHOLD) begin
        thr_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      up_cnt_r <= '0;
      dn_cnt_r <= '0;
      sp_r     <= '0;
      tot_r    <= '0;
      tgt_r    <= '0;
      done_r   <= 1'b0;
      down_r   <= 1'b0;
    end else begin
      up_cnt_r <= up_cnt_nxt;
      dn_cnt_r <= dn_cnt_nxt;
      sp_r     <= sp_nxt;
      tot_r    <= tot_nxt;
      tgt_r    <= tgt_nxt;
      done_r   <= done_nxt;
      down_r   <= down_nxt;
    end
  end

  // datapath for capture, node count and divide
  always_ff @(posedge clk) begin
    unique case (ctrl.op)
      scsr_pkg::OP_FETCH: begin
        lcnt_r <= '0;
        cnt_r  <= '0;
        if (in_acc) begin
          mask_r  <= in_node_mask;
          mode_r  <= in_system_mode;
          start_r <= in_start_hydrogen;
          total_r <= in_total_setpoint;
        end
      end
      scsr_pkg::OP_COUNT: begin
        cnt_r  <= cnt_r + CNT_W'(mask_r[0]);
        mask_r <= mask_r >> 1;
        lcnt_r <= flags.count_more ? lcnt_r + LC_W'(1) : '0;
      end
      scsr_pkg::OP_DIV_INIT: begin
        rem_r  <= '0;
        quo_r  <= total_r;
        lcnt_r <= '0;
      end
      scsr_pkg::OP_DIV: begin
        rem_r  <= div_ge ? rem_diff[CNT_W-1:0] : rem2[CNT_W-1:0];
        quo_r  <= {quo_r[CB-2:0], div_ge};
        lcnt_r <= lcnt_r + LC_W'(1);
      end
      default: begin
        lcnt_r <= lcnt_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctrl.op == scsr_pkg::OP_EMIT) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.op == scsr_pkg::OP_EMIT) begin
      out_sp_r   <= sp_r;
      out_tot_r  <= tot_r;
      out_tgt_r  <= tgt_r;
      out_act_r  <= act_ext[scsr_pkg::ACT_W-1:0];
      out_done_r <= done_r;
      out_down_r <= down_r;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_node_current_set  = out_sp_r;
  assign out_total_current_set = out_tot_r;
  assign out_node_target       = out_tgt_r;
  assign out_active_nodes      = out_act_r;
  assign out_ramp_down_done    = out_done_r;
  assign out_ramp_down_active  = out_down_r;

endmodule

FILE: design/scsr_checker.sv
`timescale 1ns / 1ps
`include "supply_current_setpoint_ramp_unit_macros.svh"

module scsr_checker #(
  parameter int CURRENT_BITS = scsr_pkg::CURRENT_BITS_DEF
) (
  input logic                    clk,
  input logic                    rst_n,
  input logic                    in_valid,
  input logic                    in_ready,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic [CURRENT_BITS-1:0] out_node_current_set,
  input logic [CURRENT_BITS-1:0] out_node_target,
  input logic                    out_ramp_down_done,
  input logic                    out_ramp_down_active
);

  // a waiting result stays until taken
  `SCSR_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped while stalled")

  // one request in flight at a time
  `SCSR_ASSERT_NEXT(a_one_in_flight, in_valid && in_ready, !in_ready, "request taken while busy")

  // while not ramping down, a valid result's setpoint never exceeds the target
  `SCSR_ASSERT_SAME(a_up_clamped, out_valid && !out_ramp_down_active, out_node_current_set <= out_node_target, "setpoint above target while ramping up")

  // done is only reported during ramp-down
  `SCSR_ASSERT_SAME(a_done_in_down, out_valid && out_ramp_down_done, out_ramp_down_active, "done flag outside ramp-down")

endmodule

bind supply_current_setpoint_ramp_unit scsr_checker #(
  .CURRENT_BITS(CURRENT_BITS)
) u_scsr_checker (.*);
